/* rtl/core/table_linear_interpolator_top_defines.svh */
// ----------------------------------------------------------------------------
// table_linear_interpolator_top_defines
// assertion macros used by the interpolator controller
// ----------------------------------------------------------------------------
`ifndef TABLE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TLI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tli assertion failed");

// next-cycle implication, checked outside reset
`define TLI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tli assertion failed");

`endif

/* rtl/core/tli_pkg.sv */
// ----------------------------------------------------------------------------
// tli_pkg
// types, codes and constants of the table interpolator
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TLI_POINTS = 1024;
  localparam int WORD_W     = 32;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam int DIV_CNT_W  = 6;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd63;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_END_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_POINTS   = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO_W = 2'd1;
  localparam logic [1:0] ST_SAT    = 2'd2;

  // read address selects
  localparam logic [2:0] A_ZERO = 3'd0;
  localparam logic [2:0] A_LAST = 3'd1;
  localparam logic [2:0] A_LO   = 3'd2;
  localparam logic [2:0] A_LO1  = 3'd3;
  localparam logic [2:0] A_MID  = 3'd4;

  // result selects
  localparam logic [2:0] R_WRITE = 3'd0;
  localparam logic [2:0] R_LOW   = 3'd1;
  localparam logic [2:0] R_HIGH  = 3'd2;
  localparam logic [2:0] R_ZW    = 3'd3;
  localparam logic [2:0] R_LERP  = 3'd4;

  typedef struct packed {
    logic               opcode;
    logic [9:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_pos;
  } tli_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               is_query;
  } tli_out_t;

  typedef struct packed {
    logic       latch;
    logic       mem_we;
    logic [2:0] rd_sel;
    logic       cap_a;
    logic       cap_b;
    logic       cap_mid;
    logic       search_init;
    logic       lo_last2;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic       round;
    logic       res_ld;
    logic [2:0] res_sel;
    logic       out_ld;
  } tli_cmd_t;

  typedef struct packed {
    logic opcode;
    logic below;
    logic above;
    logic done;
    logic end_mode;
    logic zero_w;
    logic out_free;
  } tli_sts_t;

endpackage

/* rtl/core/tli_ram.sv */
// ----------------------------------------------------------------------------
// tli_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/tli_dp.sv */
// ----------------------------------------------------------------------------
// tli_dp
// breakpoint stores, search pointers, multiplier, serial divider and output
// ----------------------------------------------------------------------------
module tli_dp
  import tli_pkg::*;
#(
  parameter int POINTS = TLI_POINTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tli_in_t               in_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tli_out_t              out_data,
  input  tli_cmd_t              cmd,
  output tli_sts_t              sts
);

  localparam int IW = $clog2(POINTS);

  logic                  end_mode_r;
  logic [CFG_DATA_W-1:0] pts_r;
  tli_in_t               in_r;
  logic signed [31:0]    x_a_r, y_a_r, x_b_r, y_b_r;
  logic [IW-1:0]         lo_r, hi_r;
  logic [63:0]           prod_r;
  logic [31:0]           d_r;
  logic                  neg_r, zero_r;
  logic [31:0]           rem_r;
  logic [63:0]           pq_r;
  logic [34:0]           off_r;
  logic signed [31:0]    res_val_r;
  logic [1:0]            res_st_r;
  logic                  out_valid_r;
  tli_out_t              out_data_r;

  logic [31:0]        pts32, n32;
  logic [IW-1:0]      last, last2, mid, span, raddr, waddr;
  logic               idx_ok;
  logic [31:0]        x_rd, y_rd;
  logic signed [32:0] dx, dy, dp;
  logic [32:0]        dx_abs, dy_abs, dp_abs;
  logic [32:0]        trial;
  logic               trial_ge;
  logic               inc;
  logic [64:0]        q_rnd;
  logic signed [36:0] y_ext, o_ext, sum;
  logic signed [31:0] res_val;
  logic [1:0]         res_st;

  // effective point count clamped to [2, POINTS]
  assign pts32 = 32'(pts_r);
  assign n32   = (pts32 < 32'd2) ? 32'd2 :
                 (pts32 > 32'(POINTS)) ? 32'(POINTS) : pts32;
  assign last  = IW'(n32 - 32'd1);
  assign last2 = IW'(n32 - 32'd2);
  assign mid   = IW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign span  = hi_r - lo_r;

  assign idx_ok = 32'(in_r.point_index) < 32'(POINTS);
  assign waddr  = IW'(in_r.point_index);

  always_comb begin
    case (cmd.rd_sel)
      A_ZERO:  raddr = '0;
      A_LAST:  raddr = last;
      A_LO:    raddr = lo_r;
      A_LO1:   raddr = lo_r + IW'(1);
      A_MID:   raddr = mid;
      default: raddr = '0;
    endcase
  end

  tli_ram #(.WIDTH(WORD_W), .DEPTH(POINTS)) u_x_ram (
    .clk   (clk),
    .we    (cmd.mem_we && idx_ok),
    .waddr (waddr),
    .wdata (in_r.point_x),
    .raddr (raddr),
    .rdata (x_rd)
  );

  tli_ram #(.WIDTH(WORD_W), .DEPTH(POINTS)) u_y_ram (
    .clk   (clk),
    .we    (cmd.mem_we && idx_ok),
    .waddr (waddr),
    .wdata (in_r.point_y),
    .raddr (raddr),
    .rdata (y_rd)
  );

  // segment differences and their magnitudes
  assign dx = $signed({x_b_r[31], x_b_r}) - $signed({x_a_r[31], x_a_r});
  assign dy = $signed({y_b_r[31], y_b_r}) - $signed({y_a_r[31], y_a_r});
  assign dp = $signed({in_r.query_pos[31], in_r.query_pos}) - $signed({x_a_r[31], x_a_r});
  assign dx_abs = dx[32] ? (~dx + 33'd1) : dx;
  assign dy_abs = dy[32] ? (~dy + 33'd1) : dy;
  assign dp_abs = dp[32] ? (~dp + 33'd1) : dp;

  // restoring division, one quotient bit a step
  assign trial    = {rem_r, pq_r[63]};
  assign trial_ge = trial >= {1'b0, d_r};

  // round half away from zero, clamp far beyond range
  assign inc   = {rem_r, 1'b0} >= {1'b0, d_r};
  assign q_rnd = {1'b0, pq_r} + 65'(inc);

  assign y_ext = 37'(y_a_r);
  assign o_ext = $signed({2'b00, off_r});
  assign sum   = neg_r ? (y_ext - o_ext) : (y_ext + o_ext);

  always_comb begin
    res_val = '0;
    res_st  = ST_OK;
    case (cmd.res_sel)
      R_WRITE: begin
        res_val = '0;
      end
      R_LOW: begin
        res_val = end_mode_r ? y_a_r : '0;
      end
      R_HIGH: begin
        res_val = y_b_r;
      end
      R_ZW: begin
        res_val = y_a_r;
        res_st  = ST_ZERO_W;
      end
      R_LERP: begin
        if (sum > 37'sd2147483647) begin
          res_val = 32'sh7fffffff;
          res_st  = ST_SAT;
        end else if (sum < -37'sd2147483648) begin
          res_val = 32'sh80000000;
          res_st  = ST_SAT;
        end else begin
          res_val = sum[31:0];
        end
      end
      default: res_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_mode_r  <= 1'b0;
      pts_r       <= CFG_DATA_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_END_MODE: end_mode_r <= cfg_wdata[0];
          CFG_POINTS:   pts_r      <= cfg_wdata;
          default:      pts_r      <= pts_r;
        endcase
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r <= in_data;
    end
    if (cmd.cap_a) begin
      x_a_r <= $signed(x_rd);
      y_a_r <= $signed(y_rd);
    end
    if (cmd.cap_b) begin
      x_b_r <= $signed(x_rd);
      y_b_r <= $signed(y_rd);
    end
    if (cmd.search_init) begin
      lo_r <= '0;
      hi_r <= last;
    end else if (cmd.lo_last2) begin
      lo_r <= last2;
    end else if (cmd.cap_mid) begin
      if ($signed(x_rd) <= in_r.query_pos) begin
        lo_r <= mid;
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.mul) begin
      prod_r <= dy_abs[31:0] * dp_abs[31:0];
      d_r    <= dx_abs[31:0];
      neg_r  <= (dy[32] ^ dp[32]) ^ dx[32];
      zero_r <= (dx == 33'sd0);
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      pq_r  <= prod_r;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? 32'(trial - {1'b0, d_r}) : trial[31:0];
      pq_r  <= {pq_r[62:0], trial_ge};
    end
    if (cmd.round) begin
      off_r <= (q_rnd > 65'h4_0000_0000) ? 35'h4_0000_0000 : q_rnd[34:0];
    end
    if (cmd.res_ld) begin
      res_val_r <= res_val;
      res_st_r  <= res_st;
    end
    if (cmd.out_ld) begin
      out_data_r.value    <= res_val_r;
      out_data_r.status   <= res_st_r;
      out_data_r.is_query <= in_r.opcode;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.opcode   = in_r.opcode;
  assign sts.below    = in_r.query_pos < x_a_r;
  assign sts.above    = in_r.query_pos >= x_b_r;
  assign sts.done     = span <= IW'(1);
  assign sts.end_mode = end_mode_r;
  assign sts.zero_w   = zero_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

/* rtl/core/tli_ctrl.sv */
// ----------------------------------------------------------------------------
// tli_ctrl
// sequencer for breakpoint writes, table search and interpolation
// ----------------------------------------------------------------------------
`include "table_linear_interpolator_top_defines.svh"

module tli_ctrl
  import tli_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tli_sts_t sts,
  output tli_cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_WR   = 5'd1;
  localparam logic [4:0] S_RD0  = 5'd2;
  localparam logic [4:0] S_CAP0 = 5'd3;
  localparam logic [4:0] S_CHK0 = 5'd4;
  localparam logic [4:0] S_RDL  = 5'd5;
  localparam logic [4:0] S_CAPL = 5'd6;
  localparam logic [4:0] S_CHKL = 5'd7;
  localparam logic [4:0] S_SCHK = 5'd8;
  localparam logic [4:0] S_SRD  = 5'd9;
  localparam logic [4:0] S_SCAP = 5'd10;
  localparam logic [4:0] S_RDA  = 5'd11;
  localparam logic [4:0] S_CAPA = 5'd12;
  localparam logic [4:0] S_RDB  = 5'd13;
  localparam logic [4:0] S_CAPB = 5'd14;
  localparam logic [4:0] S_MUL  = 5'd15;
  localparam logic [4:0] S_DINI = 5'd16;
  localparam logic [4:0] S_DIV  = 5'd17;
  localparam logic [4:0] S_RND  = 5'd18;
  localparam logic [4:0] S_SUM  = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  logic [4:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 in_acc;

  // nothing is taken while reset is held
  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.rd_sel  = A_ZERO;
    cmd.res_sel = R_WRITE;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.latch = 1'b1;
          state_nxt = (in_valid && 1'b1) ? S_WR : S_IDLE;
        end
      end
      S_WR: begin
        if (sts.opcode == OP_WRITE) begin
          cmd.mem_we  = 1'b1;
          cmd.res_ld  = 1'b1;
          cmd.res_sel = R_WRITE;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        cmd.rd_sel = A_ZERO;
        state_nxt  = S_CAP0;
      end
      S_CAP0: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_CHK0;
      end
      S_CHK0: begin
        if (sts.below) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = R_LOW;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_RDL;
        end
      end
      S_RDL: begin
        cmd.rd_sel = A_LAST;
        state_nxt  = S_CAPL;
      end
      S_CAPL: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_CHKL;
      end
      S_CHKL: begin
        if (sts.above && sts.end_mode) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = R_HIGH;
          state_nxt   = S_OUT;
        end else if (sts.above) begin
          // extend the last segment
          cmd.lo_last2 = 1'b1;
          state_nxt    = S_RDA;
        end else begin
          cmd.search_init = 1'b1;
          state_nxt       = S_SCHK;
        end
      end
      S_SCHK: begin
        state_nxt = sts.done ? S_RDA : S_SRD;
      end
      S_SRD: begin
        cmd.rd_sel = A_MID;
        state_nxt  = S_SCAP;
      end
      S_SCAP: begin
        cmd.rd_sel  = A_MID;
        cmd.cap_mid = 1'b1;
        state_nxt   = S_SCHK;
      end
      S_RDA: begin
        cmd.rd_sel = A_LO;
        state_nxt  = S_CAPA;
      end
      S_CAPA: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.rd_sel = A_LO1;
        state_nxt  = S_CAPB;
      end
      S_CAPB: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DINI;
      end
      S_DINI: begin
        if (sts.zero_w) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = R_ZW;
          state_nxt   = S_OUT;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        cmd.round = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = R_LERP;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `TLI_ASSERT_NXT(a_acc_busy, clk, rst_n, in_acc, state_r == S_WR)
  `TLI_ASSERT_NXT(a_div_hold, clk, rst_n, state_r == S_DIV && cnt_r != DIV_LAST, state_r == S_DIV)
  `TLI_ASSERT_IMP(a_out_free, clk, rst_n, cmd.out_ld, sts.out_free)
  `TLI_ASSERT_IMP(a_one_cap, clk, rst_n, 1'b1, $onehot0({cmd.cap_a, cmd.cap_b, cmd.cap_mid}))

endmodule

/* rtl/core/table_linear_interpolator_top.sv */
// ----------------------------------------------------------------------------
// table_linear_interpolator_top - piecewise linear lookup over a breakpoint table
// write stores the point; query returns early below the table or clamped above, else
// searches (last segment past the last x), then 64 divide steps, plus output stalls
// throughput: one word at a time, next word taken the cycle after the result loads
// reset: synchronous active low, clears control and config; table content undefined
// ----------------------------------------------------------------------------
module table_linear_interpolator_top
  import tli_pkg::*;
#(
  parameter int POINTS = TLI_POINTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tli_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tli_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tli_cmd_t cmd;
  tli_sts_t sts;

  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tli_dp #(.POINTS(POINTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
